[sv/trsp_pkg.sv]
// Shared types, constants and index helpers for the tetrahedron rest-shape precompute block.
`default_nettype none
package trsp_pkg;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NEG  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // Multiplier digit size: bits of the second operand consumed per cycle.
    localparam int DIG_BITS = 8;

    // Quotient lengths of the divider: the volume needs 64 bits, a gradient 32.
    localparam int QB_LONG  = 64;
    localparam int QB_SHORT = 32;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    typedef struct packed {
        logic start;
        logic long_q;
    } div_ctl_t;

    // Next index modulo three.
    function automatic logic [1:0] mod3_inc(input logic [1:0] v);
        logic [1:0] r;
        begin
            case (v)
                2'd0: r = 2'd1;
                2'd1: r = 2'd2;
                default: r = 2'd0;
            endcase
            return r;
        end
    endfunction

    // Flat index of a 3x3 matrix entry, row-major.
    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
        begin
            return {2'b00, r} * 4'd3 + {2'b00, c};
        end
    endfunction

endpackage
`default_nettype wire

[sv/trsp_mul_unit.sv]
// Digit-serial signed multiplier: eight bits of the second operand per cycle.
`default_nettype none
module trsp_mul_unit #(
    parameter int A_WIDTH = 67,
    parameter int B_WIDTH = 33
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        start,
    input  wire signed [A_WIDTH-1:0]   a,
    input  wire signed [B_WIDTH-1:0]   b,
    output trsp_pkg::unit_sts_t        sts,
    output logic [A_WIDTH + (B_WIDTH + trsp_pkg::DIG_BITS - 1) / trsp_pkg::DIG_BITS
                  * trsp_pkg::DIG_BITS - 1:0] prod
);
    import trsp_pkg::*;

    localparam int ND   = (B_WIDTH + DIG_BITS - 1) / DIG_BITS;
    localparam int PADW = ND * DIG_BITS;
    localparam int PW   = A_WIDTH + PADW;
    localparam int NW   = $clog2(ND + 1);
    localparam int PPW  = A_WIDTH + DIG_BITS;

    logic [A_WIDTH-1:0]  ma_reg;
    logic [PADW-1:0]     mb_reg;
    logic [PW-1:0]       acc_reg;
    logic                neg_reg;
    logic [NW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [A_WIDTH-1:0]  a_mag;
    logic [B_WIDTH-1:0]  b_mag;
    logic [DIG_BITS-1:0] digit;
    logic [PPW-1:0]      pp;

    assign a_mag = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
    assign b_mag = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
    assign digit = mb_reg[PADW-1 -: DIG_BITS];
    assign pp    = PPW'(ma_reg) * PPW'(digit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                ma_reg   <= a_mag;
                mb_reg   <= PADW'(b_mag);
                acc_reg  <= '0;
                neg_reg  <= a[A_WIDTH-1] ^ b[B_WIDTH-1];
                cnt_reg  <= NW'(ND);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (cnt_reg != '0) begin
                    // Most significant digit first, so the sum shifts up each step.
                    acc_reg <= (acc_reg << DIG_BITS) + PW'(pp);
                    mb_reg  <= mb_reg << DIG_BITS;
                    cnt_reg <= cnt_reg - NW'(1);
                end else begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign prod = neg_reg ? PW'(-acc_reg) : acc_reg;

    always_comb begin
        sts.busy = busy_reg;
        sts.done = done_reg;
    end

endmodule
`default_nettype wire

[sv/trsp_div_unit.sv]
// Restoring divider with a bounded quotient, overflow flag and round-half-up.
`default_nettype none
module trsp_div_unit #(
    parameter int W = 200
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire trsp_pkg::div_ctl_t     ctl,
    input  wire [W-1:0]                 num,
    input  wire [W-1:0]                 den,
    output trsp_pkg::unit_sts_t         sts,
    output logic [trsp_pkg::QB_LONG:0]  quo,
    output logic                        ovf
);
    import trsp_pkg::*;

    localparam int NW = $clog2(QB_LONG + 1);

    typedef enum logic [1:0] {D_IDLE, D_CHK, D_STEP, D_RND} dstate_t;

    dstate_t              state_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         dsh_reg;
    logic [QB_LONG-1:0]   q_reg;
    logic [NW-1:0]        cnt_reg;
    logic                 ovf_reg;
    logic [QB_LONG:0]     quo_reg;
    logic                 done_reg;

    logic [W-1:0]         d1;
    logic                 ge;

    assign d1 = dsh_reg >> 1;
    assign ge = rem_reg >= d1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (ctl.start) begin
                        rem_reg   <= num;
                        dsh_reg   <= ctl.long_q ? (den << QB_LONG) : (den << QB_SHORT);
                        cnt_reg   <= ctl.long_q ? NW'(QB_LONG) : NW'(QB_SHORT);
                        q_reg     <= '0;
                        state_reg <= D_CHK;
                    end
                end
                D_CHK: begin
                    // A quotient that does not fit the chosen length is flagged.
                    ovf_reg   <= rem_reg >= dsh_reg;
                    state_reg <= D_STEP;
                end
                D_STEP: begin
                    if (ge) begin
                        rem_reg <= rem_reg - d1;
                    end
                    q_reg   <= {q_reg[QB_LONG-2:0], ge};
                    dsh_reg <= d1;
                    cnt_reg <= cnt_reg - NW'(1);
                    if (cnt_reg == NW'(1)) begin
                        state_reg <= D_RND;
                    end
                end
                D_RND: begin
                    quo_reg   <= {1'b0, q_reg} + (QB_LONG + 1)'((rem_reg << 1) >= dsh_reg);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    assign quo = quo_reg;
    assign ovf = ovf_reg;

    always_comb begin
        sts.busy = (state_reg != D_IDLE);
        sts.done = done_reg;
    end

endmodule
`default_nettype wire

[sv/tet_rest_shape_precompute_top.sv]
// Top level of the tetrahedron rest-shape precompute: corner store, sequencer, result register.
//
// Takes the four rest corners of a linear tetrahedron, one item per corner, and after the
// fourth returns four items, one per corner, with the shape-function gradient, the rest volume
// |det|/6, a status and tlast on corner 3. The fourth corner starts a pass through one shared
// digit-serial multiplier (21 products) and one shared restoring divider (the volume, then
// twelve gradient quotients); s_tready is low from the fourth corner until the last result
// has been loaded into the output register. A zero determinant skips both divisions. The last
// result may still wait in the output register while the corners of the next element come in.
`default_nettype none
module tet_rest_shape_precompute_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire [95:0]   s_tdata,   // pos_x, pos_y, pos_z
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [167:0] m_tdata,   // node, grad_x, grad_y, grad_z, volume, zero fill
    output logic [1:0]   m_tuser,   // status
    output logic         m_tlast
);
    import trsp_pkg::*;

    localparam int EW    = COORD_WIDTH + 1;
    localparam int AW    = 2 * EW + 1;
    localparam int SW    = AW + 1;
    localparam int DTW   = 3 * EW + 1;
    localparam int W     = 3 * COORD_WIDTH + 2 * FRAC_BITS + 72;
    localparam int XW    = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
    localparam int ND    = (EW + DIG_BITS - 1) / DIG_BITS;
    localparam int PW    = AW + ND * DIG_BITS;
    localparam int VSH_N = (3 * FRAC_BITS <= 32) ? 32 - 3 * FRAC_BITS : 0;
    localparam int VSH_D = (3 * FRAC_BITS > 32) ? 3 * FRAC_BITS - 32 : 0;

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_MUL_GO, S_MUL_WT, S_STAT,
        S_VOL_GO, S_VOL_WT, S_GRD_GO, S_GRD_WT, S_OUT
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    cnt_reg, cnt_next;
    logic signed [COORD_WIDTH-1:0] held_reg [0:8];
    logic signed [COORD_WIDTH-1:0] held_next [0:8];
    logic signed [COORD_WIDTH-1:0] c3_reg [0:2];
    logic signed [COORD_WIDTH-1:0] c3_next [0:2];
    logic signed [EW-1:0]          e_reg [0:8];
    logic signed [EW-1:0]          e_next [0:8];
    logic signed [AW-1:0]          adj_reg [0:8];
    logic signed [AW-1:0]          adj_next [0:8];
    logic signed [SW-1:0]          csum_reg [0:2];
    logic signed [SW-1:0]          csum_next [0:2];
    logic signed [DTW-1:0]         det_reg, det_next;
    logic [1:0]                    row_reg, row_next;
    logic [1:0]                    col_reg, col_next;
    logic                          ph_reg, ph_next;
    logic                          dmode_reg, dmode_next;
    logic [1:0]                    k_reg, k_next;
    logic [1:0]                    c_reg, c_next;
    logic [31:0]                   grad_reg [0:2];
    logic [31:0]                   grad_next [0:2];
    logic [62:0]                   vol_reg, vol_next;
    status_t                       status_reg, status_next;
    logic                          gneg_reg, gneg_next;
    logic                          m_valid_reg, m_valid_next;
    logic [167:0]                  m_data_reg, m_data_next;
    status_t                       m_user_reg, m_user_next;
    logic                          m_last_reg, m_last_next;

    logic [XW-1:0]                 in_raw [0:2];
    logic signed [COORD_WIDTH-1:0] in_coord [0:2];
    logic                          mul_start;
    logic signed [AW-1:0]          mul_a;
    logic signed [EW-1:0]          mul_b;
    logic signed [PW-1:0]          mul_prod;
    unit_sts_t                     mul_sts;
    div_ctl_t                      div_ctl;
    logic [W-1:0]                  div_num, div_den;
    logic [QB_LONG:0]              div_quo;
    logic                          div_ovf;
    unit_sts_t                     div_sts;
    logic [DTW-1:0]                det_abs;
    logic signed [AW-1:0]          adj_diff;
    logic signed [SW-1:0]          sval;
    logic [SW-1:0]                 smag;
    logic [32:0]                   lim, mag;
    logic [1:0]                    km1;
    logic                          out_free;

    // Only the low COORD_WIDTH bits of a field are read; a width above 32 is zero-filled.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_raw[i]   = XW'(s_tdata[32*i +: 32]);
            in_coord[i] = in_raw[i][COORD_WIDTH-1:0];
        end
    end

    assign det_abs  = det_reg[DTW-1] ? DTW'(-det_reg) : DTW'(det_reg);
    assign km1      = k_reg - 2'd1;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Multiplier operands: cofactor products first, then the first-row expansion.
    always_comb begin
        logic [1:0] ia, ib, ip, iq;
        ia = mod3_inc(col_reg);
        ib = mod3_inc(ia);
        ip = mod3_inc(row_reg);
        iq = mod3_inc(ip);
        if (dmode_reg) begin
            mul_a = adj_reg[idx3(row_reg, 2'd0)];
            mul_b = e_reg[idx3(2'd0, row_reg)];
        end else if (!ph_reg) begin
            mul_a = AW'(e_reg[idx3(ia, ip)]);
            mul_b = e_reg[idx3(ib, iq)];
        end else begin
            mul_a = AW'(e_reg[idx3(ia, iq)]);
            mul_b = e_reg[idx3(ib, ip)];
        end
    end

    trsp_mul_unit #(
        .A_WIDTH (AW),
        .B_WIDTH (EW)
    ) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .sts     (mul_sts),
        .prod    (mul_prod)
    );

    trsp_div_unit #(
        .W (W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl),
        .num     (div_num),
        .den     (div_den),
        .sts     (div_sts),
        .quo     (div_quo),
        .ovf     (div_ovf)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        held_next    = held_reg;
        c3_next      = c3_reg;
        e_next       = e_reg;
        adj_next     = adj_reg;
        csum_next    = csum_reg;
        det_next     = det_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        ph_next      = ph_reg;
        dmode_next   = dmode_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        grad_next    = grad_reg;
        vol_next     = vol_reg;
        status_next  = status_reg;
        gneg_next    = gneg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        mul_start    = 1'b0;
        div_ctl      = '0;
        div_num      = '0;
        div_den      = '0;
        adj_diff     = AW'(adj_reg[idx3(row_reg, col_reg)] - AW'(mul_prod));
        sval         = (k_reg == 2'd0) ? SW'(-csum_reg[c_reg])
                                       : SW'(adj_reg[idx3(km1, c_reg)]);
        smag         = sval[SW-1] ? SW'(-sval) : SW'(sval);
        lim          = gneg_reg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
        mag          = div_ovf ? lim : div_quo[32:0];
        if (mag > lim) begin
            mag = lim;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (cnt_reg == 2'd3) begin
                        for (int i = 0; i < 3; i++) begin
                            c3_next[i] = in_coord[i];
                        end
                        cnt_next   = 2'd0;
                        state_next = S_EDGE;
                    end else begin
                        for (int i = 0; i < 3; i++) begin
                            held_next[idx3(cnt_reg, 2'(i))] = in_coord[i];
                        end
                        cnt_next = cnt_reg + 2'd1;
                    end
                end
            end
            S_EDGE: begin
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        e_next[r*3+k] = EW'((k < 2) ? held_reg[((k+1)%3)*3+r] : c3_reg[r])
                                      - EW'(held_reg[r]);
                    end
                    csum_next[r] = '0;
                end
                det_next   = '0;
                row_next   = 2'd0;
                col_next   = 2'd0;
                ph_next    = 1'b0;
                dmode_next = 1'b0;
                state_next = S_MUL_GO;
            end
            S_MUL_GO: begin
                mul_start  = 1'b1;
                state_next = S_MUL_WT;
            end
            S_MUL_WT: begin
                if (mul_sts.done) begin
                    state_next = S_MUL_GO;
                    if (dmode_reg) begin
                        det_next = det_reg + DTW'(mul_prod);
                        if (row_reg == 2'd2) begin
                            state_next = S_STAT;
                        end else begin
                            row_next = row_reg + 2'd1;
                        end
                    end else if (!ph_reg) begin
                        adj_next[idx3(row_reg, col_reg)] = AW'(mul_prod);
                        ph_next = 1'b1;
                    end else begin
                        adj_next[idx3(row_reg, col_reg)] = adj_diff;
                        csum_next[col_reg] = csum_reg[col_reg] + SW'(adj_diff);
                        ph_next = 1'b0;
                        if (col_reg == 2'd2) begin
                            col_next = 2'd0;
                            if (row_reg == 2'd2) begin
                                row_next   = 2'd0;
                                dmode_next = 1'b1;
                            end else begin
                                row_next = row_reg + 2'd1;
                            end
                        end else begin
                            col_next = col_reg + 2'd1;
                        end
                    end
                end
            end
            S_STAT: begin
                k_next = 2'd0;
                c_next = 2'd0;
                if (det_reg == '0) begin
                    status_next = ST_ZERO;
                    vol_next    = '0;
                    for (int i = 0; i < 3; i++) begin
                        grad_next[i] = '0;
                    end
                    state_next = S_OUT;
                end else begin
                    status_next = det_reg[DTW-1] ? ST_NEG : ST_OK;
                    state_next  = S_VOL_GO;
                end
            end
            S_VOL_GO: begin
                div_ctl.start  = 1'b1;
                div_ctl.long_q = 1'b1;
                div_num        = W'(det_abs) << VSH_N;
                div_den        = W'(6) << VSH_D;
                state_next     = S_VOL_WT;
            end
            S_VOL_WT: begin
                if (div_sts.done) begin
                    vol_next   = (div_ovf || div_quo[QB_LONG:QB_LONG-1] != 2'b00)
                               ? {63{1'b1}} : div_quo[62:0];
                    state_next = S_GRD_GO;
                end
            end
            S_GRD_GO: begin
                // Corner 0 uses the negated column sum of the adjugate.
                div_ctl.start = 1'b1;
                div_num       = W'(smag) << (2 * FRAC_BITS);
                div_den       = W'(det_abs);
                gneg_next     = sval[SW-1] ^ det_reg[DTW-1];
                state_next    = S_GRD_WT;
            end
            S_GRD_WT: begin
                if (div_sts.done) begin
                    grad_next[c_reg] = gneg_reg ? 32'(-mag) : 32'(mag);
                    if (c_reg == 2'd2) begin
                        state_next = S_OUT;
                    end else begin
                        c_next     = c_reg + 2'd1;
                        state_next = S_GRD_GO;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {7'd0, vol_reg, grad_reg[2], grad_reg[1], grad_reg[0], k_reg};
                    m_user_next  = status_reg;
                    m_last_next  = (k_reg == 2'd3);
                    if (k_reg == 2'd3) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        c_next     = 2'd0;
                        state_next = (status_reg == ST_ZERO) ? S_OUT : S_GRD_GO;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
            row_reg     <= 2'd0;
            col_reg     <= 2'd0;
            ph_reg      <= 1'b0;
            dmode_reg   <= 1'b0;
            k_reg       <= 2'd0;
            c_reg       <= 2'd0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            ph_reg      <= ph_next;
            dmode_reg   <= dmode_next;
            k_reg       <= k_next;
            c_reg       <= c_next;
        end
        held_reg   <= held_next;
        c3_reg     <= c3_next;
        e_reg      <= e_next;
        adj_reg    <= adj_next;
        csum_reg   <= csum_next;
        det_reg    <= det_next;
        grad_reg   <= grad_next;
        vol_reg    <= vol_next;
        status_reg <= status_next;
        gneg_reg   <= gneg_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_sts.busy)
        else $error("multiplier started while busy");

    a_ready_units_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!mul_sts.busy && !div_sts.busy))
        else $error("input ready while an arithmetic unit is busy");

    a_last_node3: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd3)))
        else $error("tlast does not match corner 3");

    a_zero_det_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == ST_ZERO) |-> (m_tdata[160:2] == '0))
        else $error("zero determinant result carries nonzero data");
`endif

endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the tetrahedron rest-shape precompute: random corners, checks of every result item.
`default_nettype none
module testbench;
    import trsp_pkg::*;

    localparam int FRAC = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  node;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic [62:0] volume;
        status_t     status;
        logic        last;
    } grad_item_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    wire           s_tready;
    logic [95:0]   s_tdata = '0;
    wire           m_tvalid;
    logic          m_tready = 1'b0;
    wire  [167:0]  m_tdata;
    wire  [1:0]    m_tuser;
    wire           m_tlast;

    tet_rest_shape_precompute_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #4 aclk = ~aclk;

    logic [95:0]  corner_queue[$];
    grad_item_t   expected_grads[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           hold_sender = 1'b0;
    bit           stim_done = 1'b0;
    bit           in_taken = 1'b0;
    int           mismatches = 0;
    int           cycles = 0;

    // Corner store of the predictor.
    logic signed [31:0] held[9];
    int                 held_count = 0;

    // Gradient adj * 2^(2*FRAC) / det, rounded half away from zero, saturated.
    function automatic logic [31:0] grad_of(logic signed [255:0] adj, logic signed [255:0] det);
        logic [255:0] num, den, q, r;
        logic         neg;
        logic [31:0]  lim;
        neg = adj[255] != det[255];
        num = (adj[255] ? -adj : adj) << (2 * FRAC);
        den = det[255] ? -det : det;
        q = num / den;
        r = num % den;
        if ((r << 1) >= den) q = q + 1;
        lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        if (q > {224'd0, lim}) q = {224'd0, lim};
        return neg ? 32'(-q[31:0]) : q[31:0];
    endfunction

    task automatic predict_corner(input logic [95:0] d);
        logic signed [255:0] e[3][3], adj[3][3], det, s;
        logic signed [31:0]  c3[3];
        logic [255:0]        vq, vr, absd;
        logic [62:0]         vol;
        status_t             st;
        grad_item_t          g;
        int                  a, b, p, q;
        for (int c = 0; c < 3; c++) c3[c] = d[32*c +: 32];
        if (held_count < 3) begin
            for (int c = 0; c < 3; c++) held[held_count*3 + c] = c3[c];
            held_count++;
            return;
        end
        held_count = 0;
        for (int rr = 0; rr < 3; rr++)
            for (int k = 0; k < 3; k++)
                e[rr][k] = 256'(signed'(k < 2 ? held[(k+1)*3 + rr] : c3[rr]))
                         - 256'(signed'(held[rr]));
        for (int rr = 0; rr < 3; rr++)
            for (int c = 0; c < 3; c++) begin
                a = (c+1) % 3; b = (c+2) % 3; p = (rr+1) % 3; q = (rr+2) % 3;
                adj[rr][c] = e[a][p]*e[b][q] - e[a][q]*e[b][p];
            end
        det = e[0][0]*adj[0][0] + e[0][1]*adj[1][0] + e[0][2]*adj[2][0];
        st = (det == 0) ? ST_ZERO : (det < 0 ? ST_NEG : ST_OK);
        vol = '0;
        if (st != ST_ZERO) begin
            // |det| is Q48; shift to Q32 by dividing by 6 * 2^16.
            absd = det[255] ? -det : det;
            vq = absd / (256'd6 << (3*FRAC - 32));
            vr = absd % (256'd6 << (3*FRAC - 32));
            if ((vr << 1) >= (256'd6 << (3*FRAC - 32))) vq = vq + 1;
            vol = (vq > 256'h7FFF_FFFF_FFFF_FFFF) ? 63'h7FFF_FFFF_FFFF_FFFF : vq[62:0];
        end
        for (int k = 0; k < 4; k++) begin
            logic [31:0] gv[3];
            for (int c = 0; c < 3; c++) begin
                s = (k == 0) ? -(adj[0][c] + adj[1][c] + adj[2][c]) : adj[k-1][c];
                gv[c] = (st == ST_ZERO) ? 32'd0 : grad_of(s, det);
            end
            g.node = 2'(k); g.gx = gv[0]; g.gy = gv[1]; g.gz = gv[2];
            g.volume = vol; g.status = st; g.last = (k == 3);
            expected_grads.push_back(g);
        end
    endtask

    // Driver.
    always @(negedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            // accepted at the last rising edge; sampled there by the predictor block below
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        in_taken = aresetn && s_tvalid && s_tready;
        if (in_taken) predict_corner(s_tdata);
    end

    bit offered = 1'b0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                // keep holding the current item
            end else if (corner_queue.size() > 0 && !hold_sender &&
                         $urandom_range(99) >= send_idle_pct) begin
                s_tdata <= corner_queue.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        grad_item_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.node = m_tdata[1:0];
            got.gx = m_tdata[33:2];
            got.gy = m_tdata[65:34];
            got.gz = m_tdata[97:66];
            got.volume = m_tdata[160:98];
            got.status = status_t'(m_tuser);
            got.last = m_tlast;
            if (expected_grads.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item: %p", got);
            end else begin
                want = expected_grads.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [95:0] pack3(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2 << 16)) - (1 << 16));
        endcase
    endfunction

    task automatic push_element(input logic [31:0] ox, oy, oz, input int scale, input bit flat);
        logic [31:0] d[3];
        corner_queue.push_back(pack3(ox, oy, oz));
        for (int k = 0; k < 3; k++) begin
            for (int c = 0; c < 3; c++) d[c] = $urandom_range(3) == 0 ? rnd_coord()
                                             : 32'($signed($urandom_range(2*scale)) - scale);
            if (flat) d[2] = oz;
            corner_queue.push_back(pack3(ox + d[0], oy + d[1], d[2] + (flat ? 0 : oz)));
        end
    endtask

    task automatic wait_drain();
        while (corner_queue.size() > 0 || s_tvalid || expected_grads.size() > 0)
            @(posedge aclk);
        repeat (800) @(posedge aclk);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        // Unit element, its mirror, a degenerate one, the coordinate extremes, a one-LSB element and a bit-pattern one.
        corner_queue.push_back(pack3(0, 0, 0));
        corner_queue.push_back(pack3(ONE, 0, 0));
        corner_queue.push_back(pack3(0, ONE, 0));
        corner_queue.push_back(pack3(0, 0, ONE));
        corner_queue.push_back(pack3(0, 0, 0));
        corner_queue.push_back(pack3(0, ONE, 0));
        corner_queue.push_back(pack3(ONE, 0, 0));
        corner_queue.push_back(pack3(0, 0, ONE));
        for (int k = 0; k < 4; k++) corner_queue.push_back(pack3(ONE, 2*ONE, 3*ONE));
        corner_queue.push_back(pack3(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        corner_queue.push_back(pack3(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
        corner_queue.push_back(pack3(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
        corner_queue.push_back(pack3(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        corner_queue.push_back(pack3(0, 0, 0));
        corner_queue.push_back(pack3(1, 0, 0));
        corner_queue.push_back(pack3(0, 1, 0));
        corner_queue.push_back(pack3(0, 0, 1));
        corner_queue.push_back(pack3(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        corner_queue.push_back(pack3(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0));
        corner_queue.push_back(pack3(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_0F0F));
        corner_queue.push_back(pack3(32'h1234_5678, 32'h8765_4321, 32'h0000_FFFF));
        wait_drain();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 3 ? 35 : 65) : 0;
            recv_stall_pct = (ph == 2) ? 65 : (ph == 3 ? 35 : 0);
            for (int n = 0; n < 15; n++)
                push_element(rnd_coord(), rnd_coord(), rnd_coord(),
                             $urandom_range(1) ? (4 << 16) : 200, $urandom_range(9) == 0);
            if (ph == 1) begin
                // Pause the sender until everything already predicted is out.
                while (corner_queue.size() > 32) @(posedge aclk);
                hold_sender = 1'b1;
                while (s_tvalid || expected_grads.size() > 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            wait_drain();
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
